FILE: src/sparse_svm_kernel_evaluator_core_assert.svh
// Assertion macros shared by the kernel evaluator RTL.
`ifndef SPARSE_SVM_KERNEL_EVALUATOR_CORE_ASSERT_SVH
`define SPARSE_SVM_KERNEL_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define SSKE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kernel evaluator assertion failed");

// next-cycle implication
`define SSKE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kernel evaluator assertion failed");

`endif

FILE: src/sske_pkg.sv
package sske_pkg;

    localparam int FEATURES_DEF   = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int EPOCH_W        = 8;
    localparam int EXP_TERMS      = 13;
    localparam int DIV_STEPS      = 64;

    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [63:0] EXP_LIMIT = 64'd190530846208;
    localparam logic [63:0] MAG_POS   = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MAG_NEG   = 64'h8000_0000_0000_0000;

    localparam logic [1:0] KIND_LINEAR  = 2'd0;
    localparam logic [1:0] KIND_POLY    = 2'd1;
    localparam logic [1:0] KIND_RBF     = 2'd2;
    localparam logic [1:0] KIND_SIGMOID = 2'd3;

    localparam logic [1:0] REG_KIND   = 2'd0;
    localparam logic [1:0] REG_DEGREE = 2'd1;
    localparam logic [1:0] REG_GAMMA  = 2'd2;
    localparam logic [1:0] REG_OFFSET = 2'd3;

    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  degree;
        logic [31:0] gamma;
        logic [31:0] offset;
        logic [63:0] dot;
        logic [63:0] norm_first;
        logic [63:0] norm_second;
        logic        acc_ovf;
    } eval_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
        logic        flag;
    } eval_rsp_t;

    function automatic logic [64:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return {1'b1, (s[64] ? MAG_NEG : MAG_POS)};
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic [64:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return {1'b1, (s[64] ? MAG_NEG : MAG_POS)};
        return {1'b0, s[63:0]};
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'h0 - v) : v;
    endfunction

    function automatic logic [63:0] to_s64(input logic neg, input logic [63:0] m);
        if (!neg) return m;
        if (m[63]) return MAG_NEG;
        return 64'h0 - m;
    endfunction

    function automatic logic [63:0] neg_bits(input logic neg, input logic [63:0] m);
        return neg ? (64'h0 - m) : m;
    endfunction

endpackage

FILE: src/sske_div.sv
module sske_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import sske_pkg::*;

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dv_reg;
    logic [6:0]  cnt_reg;
    logic        done_reg;
    logic [64:0] sh;
    logic [64:0] diff;
    logic        ge;

    assign sh   = {rem_reg, quo_reg[63]};
    assign diff = sh - {1'b0, dv_reg};
    assign ge   = sh >= {1'b0, dv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg <= '0;
                quo_reg <= dividend;
                dv_reg  <= divisor;
                cnt_reg <= 7'(DIV_STEPS);
            end else if (cnt_reg != '0) begin
                rem_reg <= ge ? diff[63:0] : sh[63:0];
                quo_reg <= {quo_reg[62:0], ge};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/sske_eval.sv
module sske_eval (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  sske_pkg::eval_req_t req,
    output sske_pkg::eval_rsp_t rsp
);
    import sske_pkg::*;

    typedef enum logic [4:0] {
        E_IDLE, E_GM0, E_GM1, E_GM2, E_T1, E_PW, E_PWR,
        E_QM0, E_QM1, E_QM2, E_QM3, E_QM4,
        E_D1, E_D2, E_D3, E_D4, E_RB, E_TH1, E_TH2, E_TH3,
        E_EX0, E_EX1, E_EX2, E_EX3, E_EX4, E_EX5
    } state_t;

    state_t      state_reg, ret_gm_reg, ret_qm_reg, ret_ex_reg;
    logic        done_reg, flag_reg;
    logic [63:0] value_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;
    logic [63:0] gm_m_reg, gm_lim_reg, gm_hi_reg, gm_res_reg;
    logic        gm_ov_reg, tov_reg, pov_reg, pneg_reg, tneg_reg;
    logic [63:0] qa_reg, qb_reg, qlim_reg, qs_reg, qres_reg;
    logic        qov_reg;
    logic [63:0] p_reg, mt_reg, plim_reg, d_reg, q_reg;
    logic [3:0]  cnt_reg;
    logic [63:0] ex_z_reg, ex_r_reg, ex_term_reg, ex_sum_reg, ex_res_reg;
    logic [5:0]  ex_n_reg;
    logic [2:0]  ex_bit_reg;
    logic [3:0]  ex_k_reg;

    logic [63:0] gm_sum, t_val, t_mag, ln2_sh, div_dividend, div_divisor, div_quot, offs;
    logic        gm_over, div_start, div_done;
    logic [64:0] t_sum, q_add, d_sum, d_sub;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            E_GM0: begin mul_a = gm_m_reg[63:32]; mul_b = req.gamma; end
            E_GM1: begin mul_a = gm_m_reg[31:0];  mul_b = req.gamma; end
            E_QM0: begin mul_a = qa_reg[63:32];   mul_b = qb_reg[63:32]; end
            E_QM1: begin mul_a = qa_reg[63:32];   mul_b = qb_reg[31:0]; end
            E_QM2: begin mul_a = qa_reg[31:0];    mul_b = qb_reg[63:32]; end
            E_QM3: begin mul_a = qa_reg[31:0];    mul_b = qb_reg[31:0]; end
            default: ;
        endcase
    end

    assign gm_sum  = {gm_hi_reg[47:0], 16'h0} + {16'h0, prod_reg[63:16]};
    assign gm_over = gm_hi_reg > {16'h0, gm_lim_reg[63:16]};
    assign offs    = {{16{req.offset[31]}}, req.offset, 16'h0};
    assign t_sum   = sat_add64(to_s64(req.dot[63], gm_res_reg), offs);
    assign t_val   = t_sum[63:0];
    assign t_mag   = mag64(t_val);
    assign q_add   = {1'b0, qs_reg}
                   + {1'b0, ((state_reg == E_QM4) ? {32'h0, prod_reg[63:32]} : prod_reg)};
    assign d_sum   = sat_add64(req.norm_first, req.norm_second);
    assign d_sub   = sat_sub64(d_reg, req.dot);
    assign ln2_sh  = LN2_Q32 << ex_bit_reg;

    assign div_start    = (state_reg == E_EX3) || (state_reg == E_TH1 && ex_res_reg != '0);
    assign div_dividend = (state_reg == E_EX3) ? qres_reg
                        : {ONE_Q32[31:0] - ex_res_reg[31:0], 32'h0};
    assign div_divisor  = (state_reg == E_EX3) ? {60'h0, ex_k_reg} : (ONE_Q32 + ex_res_reg);

    sske_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        if (req.kind == KIND_LINEAR) begin
                            done_reg  <= 1'b1;
                            value_reg <= req.dot;
                            flag_reg  <= req.acc_ovf;
                        end else begin
                            gm_m_reg   <= mag64(req.dot);
                            gm_lim_reg <= req.dot[63] ? MAG_NEG : MAG_POS;
                            gm_ov_reg  <= 1'b0;
                            ret_gm_reg <= E_T1;
                            state_reg  <= E_GM0;
                        end
                    end
                end
                E_GM0: state_reg <= E_GM1;
                E_GM1: begin
                    gm_hi_reg <= prod_reg;
                    state_reg <= E_GM2;
                end
                E_GM2: begin
                    if (gm_over || gm_sum > gm_lim_reg) begin
                        gm_res_reg <= gm_lim_reg;
                        gm_ov_reg  <= 1'b1;
                    end else begin
                        gm_res_reg <= gm_sum;
                    end
                    state_reg <= ret_gm_reg;
                end
                E_T1: begin
                    tov_reg  <= gm_ov_reg | t_sum[64];
                    tneg_reg <= t_val[63];
                    case (req.kind)
                        KIND_POLY: begin
                            if (req.degree == '0) begin
                                done_reg  <= 1'b1;
                                value_reg <= ONE_Q32;
                                flag_reg  <= req.acc_ovf;
                                state_reg <= E_IDLE;
                            end else begin
                                pneg_reg  <= t_val[63] & req.degree[0];
                                plim_reg  <= (t_val[63] & req.degree[0]) ? MAG_NEG : MAG_POS;
                                mt_reg    <= t_mag;
                                p_reg     <= ONE_Q32;
                                cnt_reg   <= '0;
                                pov_reg   <= 1'b0;
                                state_reg <= E_PW;
                            end
                        end
                        KIND_RBF: state_reg <= E_D1;
                        default: begin
                            ex_z_reg   <= t_mag[63] ? '1 : {t_mag[62:0], 1'b0};
                            ret_ex_reg <= E_TH1;
                            state_reg  <= E_EX0;
                        end
                    endcase
                end
                E_PW: begin
                    if (cnt_reg < req.degree && !pov_reg) begin
                        qa_reg     <= p_reg;
                        qb_reg     <= mt_reg;
                        qlim_reg   <= plim_reg;
                        qov_reg    <= 1'b0;
                        ret_qm_reg <= E_PWR;
                        state_reg  <= E_QM0;
                    end else begin
                        done_reg  <= 1'b1;
                        value_reg <= neg_bits(pneg_reg, p_reg);
                        flag_reg  <= req.acc_ovf | tov_reg | pov_reg;
                        state_reg <= E_IDLE;
                    end
                end
                E_PWR: begin
                    p_reg     <= qres_reg;
                    pov_reg   <= pov_reg | qov_reg;
                    cnt_reg   <= cnt_reg + 4'd1;
                    state_reg <= E_PW;
                end
                E_QM0: state_reg <= E_QM1;
                E_QM1: begin
                    if (prod_reg[63:32] != '0) begin
                        qres_reg  <= qlim_reg;
                        qov_reg   <= 1'b1;
                        state_reg <= ret_qm_reg;
                    end else begin
                        qs_reg    <= {prod_reg[31:0], 32'h0};
                        state_reg <= E_QM2;
                    end
                end
                E_QM2, E_QM3: begin
                    if (q_add[64]) begin
                        qres_reg  <= qlim_reg;
                        qov_reg   <= 1'b1;
                        state_reg <= ret_qm_reg;
                    end else begin
                        qs_reg    <= q_add[63:0];
                        state_reg <= (state_reg == E_QM2) ? E_QM3 : E_QM4;
                    end
                end
                E_QM4: begin
                    if (q_add[64] || q_add[63:0] > qlim_reg) begin
                        qres_reg <= qlim_reg;
                        qov_reg  <= 1'b1;
                    end else begin
                        qres_reg <= q_add[63:0];
                    end
                    state_reg <= ret_qm_reg;
                end
                E_D1: begin
                    d_reg     <= d_sum[63:0];
                    state_reg <= E_D2;
                end
                E_D2: begin
                    d_reg     <= d_sub[63:0];
                    state_reg <= E_D3;
                end
                E_D3: begin
                    gm_m_reg   <= d_sub[63] ? '0 : d_sub[63:0];
                    gm_lim_reg <= MAG_POS;
                    ret_gm_reg <= E_D4;
                    state_reg  <= E_GM0;
                end
                E_D4: begin
                    ex_z_reg   <= gm_res_reg;
                    ret_ex_reg <= E_RB;
                    state_reg  <= E_EX0;
                end
                E_RB: begin
                    done_reg  <= 1'b1;
                    value_reg <= ex_res_reg;
                    flag_reg  <= req.acc_ovf;
                    state_reg <= E_IDLE;
                end
                E_TH1: begin
                    if (ex_res_reg == '0) begin
                        q_reg     <= ONE_Q32;
                        state_reg <= E_TH3;
                    end else begin
                        state_reg <= E_TH2;
                    end
                end
                E_TH2: begin
                    if (div_done) begin
                        q_reg     <= div_quot;
                        state_reg <= E_TH3;
                    end
                end
                E_TH3: begin
                    done_reg  <= 1'b1;
                    value_reg <= neg_bits(tneg_reg, q_reg);
                    flag_reg  <= req.acc_ovf;
                    state_reg <= E_IDLE;
                end
                E_EX0: begin
                    if (ex_z_reg >= EXP_LIMIT) begin
                        ex_res_reg <= '0;
                        state_reg  <= ret_ex_reg;
                    end else begin
                        ex_r_reg   <= ex_z_reg;
                        ex_n_reg   <= '0;
                        ex_bit_reg <= 3'd5;
                        state_reg  <= E_EX1;
                    end
                end
                E_EX1: begin
                    if (ex_r_reg >= ln2_sh) begin
                        ex_r_reg           <= ex_r_reg - ln2_sh;
                        ex_n_reg[ex_bit_reg] <= 1'b1;
                    end
                    if (ex_bit_reg == '0) begin
                        ex_term_reg <= ONE_Q32;
                        ex_sum_reg  <= ONE_Q32;
                        ex_k_reg    <= 4'd1;
                        state_reg   <= E_EX2;
                    end else begin
                        ex_bit_reg <= ex_bit_reg - 3'd1;
                    end
                end
                E_EX2: begin
                    qa_reg     <= ex_term_reg;
                    qb_reg     <= ex_r_reg;
                    qlim_reg   <= '1;
                    qov_reg    <= 1'b0;
                    ret_qm_reg <= E_EX3;
                    state_reg  <= E_QM0;
                end
                E_EX3: state_reg <= E_EX4;
                E_EX4: begin
                    if (div_done) begin
                        ex_term_reg <= div_quot;
                        ex_sum_reg  <= ex_k_reg[0] ? (ex_sum_reg - div_quot)
                                                   : (ex_sum_reg + div_quot);
                        if (ex_k_reg == 4'(EXP_TERMS)) begin
                            state_reg <= E_EX5;
                        end else begin
                            ex_k_reg  <= ex_k_reg + 4'd1;
                            state_reg <= E_EX2;
                        end
                    end
                end
                E_EX5: begin
                    ex_res_reg <= ex_sum_reg >> ex_n_reg;
                    state_reg  <= ret_ex_reg;
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = value_reg;
    assign rsp.flag  = flag_reg;

endmodule

FILE: src/sparse_svm_kernel_evaluator_core.sv
// Element words pass through accept, store read and accumulate; one word at a time.
// After the last second-vector word, the kernel value is evaluated; radial basis and
// sigmoid use a 13-term series, each term through the shared bit-serial divider.
// After reset, and after every 255th result, a tag-clearing pass over all FEATURES
// entries runs while no word is accepted; only reset restores configuration defaults.
module sparse_svm_kernel_evaluator_core #(
    parameter int FEATURES   = sske_pkg::FEATURES_DEF,
    parameter int VALUE_BITS = sske_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // feature_index[9:0], element_value[41:10], zero pad
    input  logic        s_tuser,   // operation
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // kernel_value[63:0]
    output logic        m_tuser,   // saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sske_pkg::*;

    localparam int ADDR_W = $clog2(FEATURES);
    localparam int WORD_W = EPOCH_W + VALUE_BITS;

    typedef enum logic [2:0] {T_CLEAR, T_IDLE, T_READ, T_ACC, T_EVAL, T_WAIT} state_t;

    state_t                         state_reg;
    logic [ADDR_W-1:0]              clr_addr_reg;
    logic [EPOCH_W-1:0]             epoch_reg;
    logic [63:0]                    dot_reg, n1_reg, n2_reg;
    logic                           ovf_reg;
    logic                           m_tvalid_reg, m_tuser_reg;
    logic [63:0]                    m_tdata_reg;
    logic [1:0]                     kind_reg;
    logic [3:0]                     degree_reg;
    logic [31:0]                    gamma_reg, offset_reg;
    logic                           op_reg, last_reg, inr_reg, mark_reg;
    logic [ADDR_W-1:0]              addr_reg;
    logic signed [VALUE_BITS-1:0]   v_reg;
    logic signed [2*VALUE_BITS-1:0] pvv_reg, pfv_reg;
    logic [WORD_W-1:0]              mem [FEATURES];
    logic [WORD_W-1:0]              rd_data_reg;

    logic                           acc, cfg_wr, mem_we, eval_start;
    logic [ADDR_W+9:0]              idx_wide;
    logic [ADDR_W-1:0]              in_addr, mem_wa;
    logic [WORD_W-1:0]              mem_wd;
    logic signed [VALUE_BITS-1:0]   stored;
    logic [64:0]                    add_n1, add_n2, add_dot;
    logic [EPOCH_W-1:0]             epoch_inc;
    eval_req_t                      eval_req;
    eval_rsp_t                      eval_rsp;

    assign s_tready = (state_reg == T_IDLE);
    assign acc      = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign idx_wide = {{ADDR_W{1'b0}}, s_tdata[9:0]};
    assign in_addr  = idx_wide[ADDR_W-1:0];
    assign stored   = rd_data_reg[VALUE_BITS-1:0];
    assign add_n1   = sat_add64(n1_reg, 64'(pvv_reg));
    assign add_n2   = sat_add64(n2_reg, 64'(pvv_reg));
    assign add_dot  = sat_add64(dot_reg, 64'(pfv_reg));
    assign epoch_inc = epoch_reg + 1'b1;
    assign eval_start = (state_reg == T_EVAL) && !m_tvalid_reg;

    assign mem_we = (state_reg == T_CLEAR)
                 || (state_reg == T_READ && op_reg == OP_FIRST && inr_reg);
    assign mem_wa = (state_reg == T_CLEAR) ? clr_addr_reg : addr_reg;
    assign mem_wd = (state_reg == T_CLEAR) ? '0 : {epoch_reg, v_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (acc) rd_data_reg <= mem[in_addr];
    end

    assign eval_req = '{kind: kind_reg, degree: degree_reg, gamma: gamma_reg,
                        offset: offset_reg, dot: dot_reg, norm_first: n1_reg,
                        norm_second: n2_reg, acc_ovf: ovf_reg};

    sske_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (eval_start),
        .req     (eval_req),
        .rsp     (eval_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_CLEAR;
            clr_addr_reg <= '0;
            epoch_reg    <= '0;
            dot_reg      <= '0;
            n1_reg       <= '0;
            n2_reg       <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            kind_reg     <= KIND_RBF;
            degree_reg   <= 4'd3;
            gamma_reg    <= 32'd65536;
            offset_reg   <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_KIND:   kind_reg   <= pwdata[1:0];
                    REG_DEGREE: degree_reg <= pwdata[3:0];
                    REG_GAMMA:  gamma_reg  <= pwdata;
                    REG_OFFSET: offset_reg <= pwdata;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            case (state_reg)
                T_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(FEATURES - 1)) begin
                        clr_addr_reg <= '0;
                        epoch_reg    <= EPOCH_W'(1);
                        state_reg    <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (acc) begin
                        op_reg    <= s_tuser;
                        addr_reg  <= in_addr;
                        v_reg     <= s_tdata[10 +: VALUE_BITS];
                        last_reg  <= s_tlast;
                        inr_reg   <= {22'h0, s_tdata[9:0]} < 32'(FEATURES);
                        state_reg <= T_READ;
                    end
                end
                T_READ: begin
                    pvv_reg   <= v_reg * v_reg;
                    pfv_reg   <= stored * v_reg;
                    mark_reg  <= rd_data_reg[VALUE_BITS +: EPOCH_W] == epoch_reg;
                    state_reg <= T_ACC;
                end
                T_ACC: begin
                    if (inr_reg) begin
                        if (op_reg == OP_FIRST) begin
                            n1_reg  <= add_n1[63:0];
                            ovf_reg <= ovf_reg | add_n1[64];
                        end else begin
                            n2_reg <= add_n2[63:0];
                            if (mark_reg) dot_reg <= add_dot[63:0];
                            ovf_reg <= ovf_reg | add_n2[64] | (mark_reg & add_dot[64]);
                        end
                    end
                    state_reg <= (op_reg == OP_SECOND && last_reg) ? T_EVAL : T_IDLE;
                end
                T_EVAL: begin
                    if (!m_tvalid_reg) state_reg <= T_WAIT;
                end
                T_WAIT: begin
                    if (eval_rsp.done) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= eval_rsp.value;
                        m_tuser_reg  <= eval_rsp.flag;
                        dot_reg      <= '0;
                        n1_reg       <= '0;
                        n2_reg       <= '0;
                        ovf_reg      <= 1'b0;
                        epoch_reg    <= epoch_inc;
                        state_reg    <= (epoch_inc == '0) ? T_CLEAR : T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_KIND:   prdata = {30'h0, kind_reg};
            REG_DEGREE: prdata = {28'h0, degree_reg};
            REG_GAMMA:  prdata = gamma_reg;
            REG_OFFSET: prdata = offset_reg;
            default:    prdata = '0;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`include "sparse_svm_kernel_evaluator_core_assert.svh"

    `SSKE_ASSERT_NEXT(a_accept_reads, aclk, aresetn, acc, state_reg == T_READ)
    `SSKE_ASSERT_IMPL(a_clear_stalls, aclk, aresetn, state_reg == T_CLEAR, !s_tready)
    `SSKE_ASSERT_NEXT(a_result_held, aclk, aresetn, eval_rsp.done, m_tvalid_reg)
    `SSKE_ASSERT_IMPL(a_epoch_live, aclk, aresetn, state_reg != T_CLEAR, epoch_reg != '0)

endmodule
